// File: design/depth_gated_box_extent_macros.svh
// Assertion macros used by the checker of the depth-gated box extent block.
// Needs nothing but the clock, reset and signal names handed in by the caller.
`ifndef DEPTH_GATED_BOX_EXTENT_MACROS_SVH
`define DEPTH_GATED_BOX_EXTENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// The consequent must hold in the cycle after the antecedent.
`define DGBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

// File: design/dgbe_pkg.sv
// Package of the depth-gated box extent block: widths, codes, reset values and types.
// Depends on nothing; every module of the block imports it.
package dgbe_pkg;

    localparam int COORD_BITS      = 24;
    localparam int CLASS_COUNT     = 64;
    localparam int CLASS_BITS      = 6;
    localparam int PROB_BITS       = 16;
    localparam int TOL_BITS        = COORD_BITS - 1;
    localparam int CLASS_IDX_BITS  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    localparam int IN_FIELD_BITS   = CLASS_BITS + PROB_BITS + 1 + COORD_BITS + 1
                                     + 3 * COORD_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = CLASS_BITS + PROB_BITS + 6 * COORD_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_DATA_BITS   = (CLASS_COUNT > TOL_BITS)
                                     ? ((CLASS_COUNT > PROB_BITS) ? CLASS_COUNT : PROB_BITS)
                                     : ((TOL_BITS > PROB_BITS) ? TOL_BITS : PROB_BITS);
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PROBABILITY = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_TOLERANCE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MASK      = 2'd2;

    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    localparam logic [PROB_BITS-1:0]   MIN_PROBABILITY_RESET = 16'd19661;
    localparam logic [TOL_BITS-1:0]    DEPTH_TOLERANCE_RESET = TOL_BITS'(300);
    localparam logic [CLASS_COUNT-1:0] CLASS_MASK_RESET      = '0;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Input fields, listed from the highest bits down; class_index is in the lowest bits.
    typedef struct packed {
        coord_t                point_z;
        coord_t                point_y;
        coord_t                point_x;
        logic                  point_valid;
        coord_t                center_depth;
        logic                  center_valid;
        logic [PROB_BITS-1:0]  probability;
        logic [CLASS_BITS-1:0] class_index;
    } in_data_t;

    typedef struct packed {
        logic     func;
        logic     last;
        in_data_t data;
    } item_t;

    // Result fields carried in tdata, listed from the highest bits down; out_class is in the lowest bits.
    typedef struct packed {
        coord_t                box_max_z;
        coord_t                box_min_z;
        coord_t                box_max_y;
        coord_t                box_min_y;
        coord_t                box_max_x;
        coord_t                box_min_x;
        logic [PROB_BITS-1:0]  out_probability;
        logic [CLASS_BITS-1:0] out_class;
    } out_data_t;

    typedef struct packed {
        logic      empty_res;
        out_data_t data;
    } result_t;

    typedef struct packed {
        logic [PROB_BITS-1:0]   min_probability;
        logic [TOL_BITS-1:0]    depth_tolerance;
        logic [CLASS_COUNT-1:0] class_mask;
    } cfg_t;

endpackage

// File: design/dgbe_cfg_regs.sv
// Configuration registers of the depth-gated box extent block.
// Depends on dgbe_pkg for register indices, widths and reset values.
module dgbe_cfg_regs
    import dgbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_PROBABILITY: cfg_next.min_probability = cfg_data[PROB_BITS-1:0];
                REG_DEPTH_TOLERANCE: cfg_next.depth_tolerance = cfg_data[TOL_BITS-1:0];
                REG_CLASS_MASK:      cfg_next.class_mask      = cfg_data[CLASS_COUNT-1:0];
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_probability <= MIN_PROBABILITY_RESET;
            cfg_reg.depth_tolerance <= DEPTH_TOLERANCE_RESET;
            cfg_reg.class_mask      <= CLASS_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/dgbe_in_stage.sv
// Input register of the depth-gated box extent block: holds one accepted transaction.
// Depends on dgbe_pkg for the item type and the tdata layout.
module dgbe_in_stage
    import dgbe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_BITS-1:0] s_tdata,
    input  logic                     s_tuser,
    input  logic                     s_tlast,
    input  logic                     advance,
    output item_t                    item,
    output logic                     item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.func <= s_tuser;
            item_reg.last <= s_tlast;
            item_reg.data <= in_data_t'(s_tdata[IN_FIELD_BITS-1:0]);
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: design/dgbe_extent.sv
// Detection state and running extents of the depth-gated box extent block.
// Depends on dgbe_pkg; decides acceptance, updates minima and maxima, forms the result.
module dgbe_extent
    import dgbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    advance,
    input  cfg_t    cfg,
    output logic    emit,
    output result_t result
);

    logic                  box_active_reg;
    logic                  box_active_next;
    logic                  any_point_reg;
    logic                  any_point_next;
    logic [CLASS_BITS-1:0] held_class_reg;
    logic [CLASS_BITS-1:0] held_class_next;
    logic [PROB_BITS-1:0]  held_probability_reg;
    logic [PROB_BITS-1:0]  held_probability_next;
    coord_t                held_center_depth_reg;
    coord_t                held_center_depth_next;
    coord_t                minima_reg [3];
    coord_t                minima_next [3];
    coord_t                maxima_reg [3];
    coord_t                maxima_next [3];

    coord_t                      coords [3];
    logic signed [COORD_BITS+1:0] diff;
    logic signed [COORD_BITS+1:0] tol_ext;
    logic                        in_range;
    logic                        class_ok;
    logic                        accept;

    assign coords[0] = item.data.point_x;
    assign coords[1] = item.data.point_y;
    assign coords[2] = item.data.point_z;

    assign diff     = (COORD_BITS+2)'(item.data.point_x)
                      - (COORD_BITS+2)'(held_center_depth_reg);
    assign tol_ext  = $signed({3'b000, cfg.depth_tolerance});
    assign in_range = (diff <= tol_ext) && (diff >= -tol_ext);

    assign class_ok = ({1'b0, item.data.class_index} < (CLASS_BITS+1)'(CLASS_COUNT))
                      && cfg.class_mask[item.data.class_index[CLASS_IDX_BITS-1:0]];
    assign accept   = (item.data.probability >= cfg.min_probability) && class_ok
                      && item.data.center_valid;

    always_comb
    begin
        box_active_next        = box_active_reg;
        any_point_next         = any_point_reg;
        held_class_next        = held_class_reg;
        held_probability_next  = held_probability_reg;
        held_center_depth_next = held_center_depth_reg;
        minima_next            = minima_reg;
        maxima_next            = maxima_reg;
        emit                   = 1'b0;

        if (item.func == FUNC_BEGIN)
        begin
            held_class_next        = item.data.class_index;
            held_probability_next  = item.data.probability;
            held_center_depth_next = item.data.center_depth;
            any_point_next         = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                minima_next[k] = COORD_MAX;
                maxima_next[k] = COORD_MIN;
            end
            box_active_next = accept && !item.last;
            emit            = accept && item.last;
        end
        else if (box_active_reg)
        begin
            if (item.data.point_valid && in_range)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (coords[k] < minima_reg[k])
                    begin
                        minima_next[k] = coords[k];
                    end
                    if (coords[k] > maxima_reg[k])
                    begin
                        maxima_next[k] = coords[k];
                    end
                end
                any_point_next = 1'b1;
            end
            if (item.last)
            begin
                box_active_next = 1'b0;
                emit            = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.empty_res            = !any_point_next;
        result.data.out_class       = held_class_next;
        result.data.out_probability = held_probability_next;
        result.data.box_min_x       = minima_next[0];
        result.data.box_max_x       = maxima_next[0];
        result.data.box_min_y       = minima_next[1];
        result.data.box_max_y       = maxima_next[1];
        result.data.box_min_z       = minima_next[2];
        result.data.box_max_z       = maxima_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_active_reg        <= 1'b0;
            any_point_reg         <= 1'b0;
            held_class_reg        <= '0;
            held_probability_reg  <= '0;
            held_center_depth_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                minima_reg[k] <= COORD_MAX;
                maxima_reg[k] <= COORD_MIN;
            end
        end
        else if (advance)
        begin
            box_active_reg        <= box_active_next;
            any_point_reg         <= any_point_next;
            held_class_reg        <= held_class_next;
            held_probability_reg  <= held_probability_next;
            held_center_depth_reg <= held_center_depth_next;
            minima_reg            <= minima_next;
            maxima_reg            <= maxima_next;
        end
    end

endmodule

// File: design/dgbe_out_stage.sv
// Result register of the depth-gated box extent block, driving the master-side stream.
// Depends on dgbe_pkg for the result type and the tdata layout.
module dgbe_out_stage
    import dgbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  result_t                   result,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    output logic                      m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'(result_reg.data);
    assign m_tuser  = result_reg.empty_res;

endmodule

// File: design/depth_gated_box_extent.sv
// Depth-gated 3D box extent: top level, built from dgbe_cfg_regs, dgbe_in_stage,
// dgbe_extent and dgbe_out_stage, with types from dgbe_pkg. The block takes one
// transaction in every clock cycle unless it is stalled as described below; a result is
// presented on the master side after the last item of an accepted detection is taken:
// the item is first held in the input register and its result is then loaded into the
// result register. The throughput is set by the result
// register: when a result is waiting there and the item in the input register would
// produce another, the input side holds tready low until the waiting result is taken.
// Items that produce no result pass through the input register even while the master
// side is stalled.
module depth_gated_box_extent
    import dgbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input fields from bit 0 up: class_index, probability, center_valid,
    // center_depth, point_valid, point_x, point_y, point_z.
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // Input field: func.
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Result fields from bit 0 up: out_class, out_probability, box_min_x, box_max_x,
    // box_min_y, box_max_y, box_min_z, box_max_z, zero padding.
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    // Result field: empty_res.
    output logic                      m_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    emit;
    result_t result;
    logic    out_free;
    logic    advance;
    logic    load;

    assign advance = item_valid && (!emit || out_free);
    assign load    = advance && emit;

    dgbe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dgbe_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    dgbe_extent u_extent (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .cfg     (cfg),
        .emit    (emit),
        .result  (result)
    );

    dgbe_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: design/dgbe_checker.sv
// Port-level checker of the depth-gated box extent block, bound to the top level.
// Depends on dgbe_pkg and on depth_gated_box_extent_macros.svh.
`include "depth_gated_box_extent_macros.svh"

module dgbe_checker
    import dgbe_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata,
    input logic                      m_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready
);

    out_data_t shown;
    logic      sentinels;
    logic      ordered;

    assign shown     = out_data_t'(m_tdata[OUT_FIELD_BITS-1:0]);
    assign sentinels = (shown.box_min_x == COORD_MAX) && (shown.box_max_x == COORD_MIN)
                       && (shown.box_min_y == COORD_MAX) && (shown.box_max_y == COORD_MIN)
                       && (shown.box_min_z == COORD_MAX) && (shown.box_max_z == COORD_MIN);
    assign ordered   = (shown.box_min_x <= shown.box_max_x)
                       && (shown.box_min_y <= shown.box_max_y)
                       && (shown.box_min_z <= shown.box_max_z);

    `DGBE_ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `DGBE_ASSERT_SAME(a_empty_sentinels, clk, rst_n, m_tvalid && m_tuser, sentinels)
    `DGBE_ASSERT_SAME(a_extent_order, clk, rst_n, m_tvalid && !m_tuser, ordered)
    `DGBE_ASSERT_SAME(a_stall_only_on_output, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind depth_gated_box_extent dgbe_checker u_checker (.*);
